>>> rtl/u16u8_pkg.sv
// shared types, constants and encode helpers for the utf-16 pattern escaper
// no dependencies; imported by every module of the block

package u16u8_pkg;

  // one job carries every byte caused by one accepted code unit
  localparam int JobBytes = 6;
  localparam int CntW     = 3;
  localparam int IdxW     = 3;

  // job queue between front and back
  localparam int QDepth   = 4;
  localparam int QPtrW    = 2;

  // characters used by the escape form
  localparam logic [7:0] BackslashChar = 8'h5C;
  localparam logic [7:0] LowerUChar    = 8'h75;
  localparam logic [7:0] AsciiLimit    = 8'h7F;

  // surrogate range prefixes
  localparam logic [5:0] HighSurPrefix = 6'b110110;
  localparam logic [5:0] LowSurPrefix  = 6'b110111;

  // configuration register indexes
  localparam logic CfgUnicode     = 1'b0;
  localparam logic CfgUnicodeSets = 1'b1;

  typedef logic [JobBytes-1:0][7:0] job_bytes_t;

  typedef struct packed {
    job_bytes_t      bytes;  // byte 0 goes out first
    logic [CntW-1:0] cnt;    // number of bytes, 1 to JobBytes
    logic            err;    // both mode flags were set
  } job_t;

  // utf-8 encoding of a code point of the basic plane
  typedef struct packed {
    logic [2:0][7:0] b;
    logic [1:0]      len;
  } enc_t;

  function automatic enc_t enc_bmp(input logic [15:0] cp);
    enc_t e;
    e = '0;
    if (cp[15:7] == 9'd0) begin
      e.b[0] = cp[7:0];
      e.len  = 2'd1;
    end else if (cp[15:11] == 5'd0) begin
      e.b[0] = {3'b110, cp[10:6]};
      e.b[1] = {2'b10, cp[5:0]};
      e.len  = 2'd2;
    end else begin
      e.b[0] = {4'b1110, cp[15:12]};
      e.b[1] = {2'b10, cp[11:6]};
      e.b[2] = {2'b10, cp[5:0]};
      e.len  = 2'd3;
    end
    return e;
  endfunction

  // lowercase hex digit
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'd0, nib};
    end else begin
      c = 8'h57 + {4'd0, nib};
    end
    return c;
  endfunction

endpackage

>>> rtl/u16u8_front.sv
// front part: accepts code units, tracks surrogate and backslash state,
// builds at most one byte job per unit; depends on u16u8_pkg

module u16u8_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                unicode_i,
  input  logic                unicode_sets_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [15:0]         unit_word_i,
  input  logic                final_unit_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output u16u8_pkg::job_t     q_job_o
);
  import u16u8_pkg::*;

  logic       odd_bs_q, odd_bs_d;
  logic       hold_q, hold_d;
  logic [9:0] held_q, held_d;

  logic       accept;
  logic       has_bytes;
  job_t       job;
  logic       err_mode, cp_mode;
  logic       is_high, is_low;
  logic [20:0] pair_cp;
  enc_t       enc_unit, enc_held;

  assign in_ready_o = ~q_full_i;
  assign accept     = in_valid_i & ~q_full_i;
  assign err_mode   = unicode_i & unicode_sets_i;
  assign cp_mode    = unicode_i | unicode_sets_i;
  assign is_high    = unit_word_i[15:10] == HighSurPrefix;
  assign is_low     = unit_word_i[15:10] == LowSurPrefix;
  assign pair_cp    = 21'h10000 + {1'b0, held_q, unit_word_i[9:0]};
  assign enc_unit   = enc_bmp(unit_word_i);
  assign enc_held   = enc_bmp({HighSurPrefix, held_q});

  // classify the unit and assemble its bytes
  always_comb begin
    job       = '0;
    has_bytes = 1'b0;
    odd_bs_d  = odd_bs_q;
    hold_d    = hold_q;
    held_d    = held_q;
    if (err_mode) begin
      job.err   = 1'b1;
      job.cnt   = CntW'(1);
      has_bytes = 1'b1;
    end else if (cp_mode) begin
      hold_d = 1'b0;
      held_d = '0;
      if (hold_q && is_low) begin
        // joined pair, four bytes
        job.bytes[0] = {5'b11110, pair_cp[20:18]};
        job.bytes[1] = {2'b10, pair_cp[17:12]};
        job.bytes[2] = {2'b10, pair_cp[11:6]};
        job.bytes[3] = {2'b10, pair_cp[5:0]};
        job.cnt      = CntW'(4);
        has_bytes    = 1'b1;
      end else begin
        // lone held surrogate goes out first
        if (hold_q) begin
          for (int k = 0; k < 3; k++) begin
            job.bytes[k] = enc_held.b[k];
          end
          job.cnt   = CntW'(3);
          has_bytes = 1'b1;
        end
        if (is_high && !final_unit_i) begin
          hold_d = 1'b1;
          held_d = unit_word_i[9:0];
        end else begin
          for (int k = 0; k < 3; k++) begin
            if (hold_q) begin
              job.bytes[k+3] = enc_unit.b[k];
            end else begin
              job.bytes[k] = enc_unit.b[k];
            end
          end
          job.cnt   = job.cnt + {1'b0, enc_unit.len};
          has_bytes = 1'b1;
        end
      end
    end else begin
      // legacy: ascii passes, the rest is \uhhhh, or uhhhh if odd_bs_q
      hold_d    = 1'b0;
      held_d    = '0;
      has_bytes = 1'b1;
      if (unit_word_i > {8'd0, AsciiLimit}) begin
        if (!odd_bs_q) begin
          job.bytes[0] = BackslashChar;
          job.bytes[1] = LowerUChar;
          job.bytes[2] = hex_char(unit_word_i[15:12]);
          job.bytes[3] = hex_char(unit_word_i[11:8]);
          job.bytes[4] = hex_char(unit_word_i[7:4]);
          job.bytes[5] = hex_char(unit_word_i[3:0]);
          job.cnt      = CntW'(6);
        end else begin
          job.bytes[0] = LowerUChar;
          job.bytes[1] = hex_char(unit_word_i[15:12]);
          job.bytes[2] = hex_char(unit_word_i[11:8]);
          job.bytes[3] = hex_char(unit_word_i[7:4]);
          job.bytes[4] = hex_char(unit_word_i[3:0]);
          job.cnt      = CntW'(5);
        end
      end else begin
        job.bytes[0] = unit_word_i[7:0];
        job.cnt      = CntW'(1);
      end
      if (unit_word_i == {8'd0, BackslashChar}) begin
        odd_bs_d = ~odd_bs_q;
      end else begin
        odd_bs_d = 1'b0;
      end
    end
    // end of pattern starts the next one fresh
    if (final_unit_i) begin
      odd_bs_d = 1'b0;
      hold_d   = 1'b0;
      held_d   = '0;
    end
  end

  assign q_push_o = accept & has_bytes;
  assign q_job_o  = job;

  // pattern state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      odd_bs_q <= 1'b0;
      hold_q   <= 1'b0;
      held_q   <= '0;
    end else if (accept) begin
      odd_bs_q <= odd_bs_d;
      hold_q   <= hold_d;
      held_q   <= held_d;
    end
  end

endmodule

>>> rtl/u16u8_queue.sv
// short job queue between front and back
// depends on u16u8_pkg

module u16u8_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  u16u8_pkg::job_t push_job_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output u16u8_pkg::job_t head_job_o
);
  import u16u8_pkg::*;

  job_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]   count_q;

  assign full_o     = count_q == (QPtrW+1)'(QDepth);
  assign empty_o    = count_q == '0;
  assign head_job_o = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (QPtrW+1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (QPtrW+1)'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o || pop_i) else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("job queue underflow");

endmodule

>>> rtl/u16u8_back.sv
// back part: takes jobs from the queue and sends their bytes one per cycle
// while out_ready_i is high, via an output register; depends on u16u8_pkg

module u16u8_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  u16u8_pkg::job_t q_job_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            run_end_o,
  output logic            flag_error_o
);
  import u16u8_pkg::*;

  job_t            cur_q;
  logic            cur_vld_q;
  logic [IdxW-1:0] idx_q;
  logic            out_vld_q, out_last_q, out_err_q;
  logic [7:0]      out_byte_q;

  logic out_free, emit, last_byte;

  assign out_free  = ~out_vld_q | out_ready_i;
  assign emit      = cur_vld_q & out_free;
  assign last_byte = idx_q == (cur_q.cnt - CntW'(1));
  assign q_pop_o   = ~q_empty_i & (~cur_vld_q | (emit & last_byte));

  // current job and byte index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q <= 1'b0;
      idx_q     <= '0;
    end else if (q_pop_o) begin
      cur_vld_q <= 1'b1;
      idx_q     <= '0;
    end else if (emit && last_byte) begin
      cur_vld_q <= 1'b0;
    end else if (emit) begin
      idx_q <= idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_job_i;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (emit) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q <= cur_q.bytes[idx_q];
      out_last_q <= last_byte;
      out_err_q  <= cur_q.err;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign out_byte_o   = out_byte_q;
  assign run_end_o    = out_last_q;
  assign flag_error_o = out_err_q;

  a_idx_in_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_vld_q |-> idx_q < cur_q.cnt) else $error("byte index past job end");

  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_err_q) |-> out_last_q && out_byte_q == 8'd0)
    else $error("error result must be a lone zero byte");

  a_emit_only_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && !last_byte |=> cur_vld_q && idx_q == $past(idx_q) + IdxW'(1))
    else $error("byte index did not advance");

endmodule

>>> rtl/utf16_pattern_to_utf8_escaper.sv
// Converts a regex pattern given as UTF-16 code units into UTF-8 bytes. With
// the u or v flag set, surrogate pairs are joined into four-byte sequences and
// a lone surrogate is sent as its own three-byte sequence; a high surrogate is
// held until the next unit or tlast. Without flags, units above 0x7F become
// lowercase \uhhhh, the backslash dropped after an odd run of backslashes.
// Both flags set gives one error result (tuser high, zero byte) per unit.
// The front takes one unit per cycle while its 4-entry job queue has room; the
// back sends one byte per cycle while the output is ready. A unit yields 1 to 6
// bytes (a held high surrogate yields none). The output byte register bounds
// throughput; bytes pass the queue entry, current job and output registers.
// Top level; depends on u16u8_pkg, u16u8_front, u16u8_queue, u16u8_back.

module utf16_pattern_to_utf8_escaper (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic        cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] unit_word
  input  logic        s_axis_tlast,   // final_unit
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast,   // run_end
  output logic        m_axis_tuser    // [0] flag_error
);
  import u16u8_pkg::*;

  logic unicode_q, unicode_sets_q;
  logic q_push, q_full, q_pop, q_empty;
  job_t push_job, head_job;

  // mode flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unicode_q      <= 1'b0;
      unicode_sets_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgUnicode:     unicode_q      <= cfg_data_i;
        CfgUnicodeSets: unicode_sets_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  u16u8_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .unicode_i      (unicode_q),
    .unicode_sets_i (unicode_sets_q),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .unit_word_i    (s_axis_tdata),
    .final_unit_i   (s_axis_tlast),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_job_o        (push_job)
  );

  u16u8_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_job_i (push_job),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .head_job_o (head_job)
  );

  u16u8_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_job_i      (head_job),
    .q_pop_o      (q_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (m_axis_tdata),
    .run_end_o    (m_axis_tlast),
    .flag_error_o (m_axis_tuser)
  );

endmodule
